// ===== sv/fsm_pkg.sv =====
// Shared types and constants for the first substring match unit.
package fsm_pkg;

    localparam int unsigned TEXT_W       = 8;
    localparam int unsigned POS_W        = 32;
    localparam int unsigned NEEDLE_LEN_W = 6;
    localparam int unsigned CFG_ADDR_W   = 3;
    localparam int unsigned CFG_DATA_W   = 64;
    localparam int unsigned WORD_BYTES   = 8;
    localparam int unsigned QUEUE_DEPTH  = 2;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_NEEDLE_LENGTH = 3'd0,
        REG_NEEDLE_WORD_0 = 3'd1,
        REG_NEEDLE_WORD_1 = 3'd2,
        REG_NEEDLE_WORD_2 = 3'd3,
        REG_NEEDLE_WORD_3 = 3'd4
    } fsm_reg_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } result_t;

endpackage

// ===== sv/fsm_front.sv =====
// Front end: needle registers, sliding window, match detection and result requests.
module fsm_front #(
    parameter int unsigned MAX_NEEDLE = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  fsm_pkg::cfg_addr_t           cfg_addr,
    input  fsm_pkg::cfg_data_t           cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [fsm_pkg::TEXT_W-1:0]   s_tdata,
    input  logic                         s_tlast,
    output logic                         push_valid,
    output fsm_pkg::result_t             push_data,
    input  logic                         push_ready
);
    import fsm_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_NEEDLE + 1);
    localparam int unsigned IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

    logic [NEEDLE_LEN_W-1:0] needle_len_reg;
    logic [TEXT_W-1:0]       needle_reg [MAX_NEEDLE];
    logic [TEXT_W-1:0]       win_reg    [MAX_NEEDLE];
    logic [TEXT_W-1:0]       win_next   [MAX_NEEDLE];
    logic [LEN_W-1:0]        fill_reg;
    logic [LEN_W-1:0]        fill_next;
    logic [POS_W-1:0]        seen_reg;
    logic [POS_W-1:0]        seen_next;
    logic                    reported_reg;
    logic                    reported_next;

    logic [LEN_W-1:0]        len_eff;
    logic [LEN_W-1:0]        fill_inc;
    logic [MAX_NEEDLE-1:0]   cmp_ok;
    logic [POS_W-1:0]        match_pos;
    logic                    saturated;
    logic                    hit;
    logic                    accept;
    logic                    shift_en;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_len_reg <= NEEDLE_LEN_W'(1);
        end else if (cfg_we && (cfg_addr == REG_NEEDLE_LENGTH)) begin
            needle_len_reg <= cfg_wdata[NEEDLE_LEN_W-1:0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_NEEDLE; k++) begin : g_lane
            logic [LEN_W-1:0] nidx;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    needle_reg[k] <= '0;
                end else if (cfg_we &&
                             (cfg_addr == CFG_ADDR_W'(int'(REG_NEEDLE_WORD_0) + k / WORD_BYTES)))
                begin
                    needle_reg[k] <= cfg_wdata[TEXT_W*(k % WORD_BYTES) +: TEXT_W];
                end
            end

            if (k == 0) begin : g_head
                assign win_next[k] = s_tdata;
            end else begin : g_tail
                assign win_next[k] = win_reg[k-1];
            end

            assign nidx      = len_eff - LEN_W'(1) - LEN_W'(k);
            assign cmp_ok[k] = (LEN_W'(k) >= len_eff) ||
                               (win_next[k] == needle_reg[nidx[IDX_W-1:0]]);
        end
    endgenerate

    always_comb begin
        if (needle_len_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (needle_len_reg > NEEDLE_LEN_W'(MAX_NEEDLE)) begin
            len_eff = LEN_W'(MAX_NEEDLE);
        end else begin
            len_eff = LEN_W'(needle_len_reg);
        end
    end

    assign fill_inc  = (fill_reg == LEN_W'(MAX_NEEDLE)) ? fill_reg : fill_reg + LEN_W'(1);
    assign saturated = (seen_reg == '1);
    assign hit       = !saturated && (fill_inc >= len_eff) && (&cmp_ok);
    assign match_pos = seen_reg - POS_W'(len_eff - LEN_W'(1));

    always_comb begin
        fill_next           = fill_reg;
        seen_next           = seen_reg;
        reported_next       = reported_reg;
        shift_en            = 1'b0;
        push_valid          = 1'b0;
        push_data.found     = 1'b0;
        push_data.position  = '0;
        if (accept) begin
            if (reported_reg) begin
                if (s_tlast) begin
                    fill_next     = '0;
                    seen_next     = '0;
                    reported_next = 1'b0;
                end
            end else begin
                shift_en  = 1'b1;
                fill_next = fill_inc;
                seen_next = saturated ? seen_reg : seen_reg + POS_W'(1);
                if (hit) begin
                    push_valid         = 1'b1;
                    push_data.found    = 1'b1;
                    push_data.position = match_pos;
                    if (s_tlast) begin
                        fill_next     = '0;
                        seen_next     = '0;
                        reported_next = 1'b0;
                    end else begin
                        reported_next = 1'b1;
                    end
                end else if (s_tlast) begin
                    push_valid    = 1'b1;
                    fill_next     = '0;
                    seen_next     = '0;
                    reported_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end else begin
            fill_reg     <= fill_next;
            seen_reg     <= seen_next;
            reported_reg <= reported_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            win_reg <= win_next;
        end
    end

`ifndef SYNTH
    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> accept)
        else $error("result request without an accepted byte");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LEN_W'(MAX_NEEDLE))
        else $error("window fill count out of range");

    a_mark_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !reported_reg && hit && !s_tlast) |=> reported_reg)
        else $error("match inside text not marked as reported");

    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (fill_reg == '0 && seen_reg == '0 && !reported_reg))
        else $error("text state not cleared after final byte");
`endif

endmodule

// ===== sv/fsm_queue.sv =====
// Two-entry queue of result requests between front end and output stage.
module fsm_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    input  fsm_pkg::result_t push_data,
    output logic             push_ready,
    output logic             pop_valid,
    output fsm_pkg::result_t pop_data,
    input  logic             pop_ready
);
    import fsm_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push_fire ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> push_ready)
        else $error("request pushed into a full queue");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_fire == pop_fire) |=> $stable(count_reg))
        else $error("queue count moved without a net push or pop");
`endif

endmodule

// ===== sv/fsm_back.sv =====
// Output stage: registers result requests and drives the result channel.
module fsm_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            pop_valid,
    input  fsm_pkg::result_t                pop_data,
    output logic                            pop_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fsm_pkg::POS_W-1:0]       m_tdata,
    output logic                            m_tuser
);
    import fsm_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    logic    load;

    assign pop_ready = !out_valid_reg || m_tready;
    assign load      = pop_valid && pop_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= pop_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg.position;
    assign m_tuser  = out_data_reg.found;

endmodule

// ===== sv/first_substring_match_unit.sv =====
// Top level of the first substring match unit.
//
// Text bytes enter on the s_ channel, one byte per request, with s_tlast on
// the final byte of a text. Each text yields exactly one result request on
// the m_ channel: m_tuser high with the zero-based start offset in m_tdata
// when the needle first occurs, or m_tuser low and m_tdata zero at the final
// byte when it does not occur. Bytes after a reported match are consumed
// without a result; the final byte then clears the text state.
// The needle is loaded through the write port: index 0 holds the length
// (1 to MAX_NEEDLE), indexes 1 to 4 hold needle bytes 0-7, 8-15, 16-23 and
// 24-31, little-endian. Write it only while no text is in flight.
// Throughput is one byte per cycle while the queue has room; the window
// compare finishes in the accepting cycle. The accepting edge writes the
// result request into the queue, and the output register loads it from
// there once that register is free, which raises m_tvalid.
// A two-entry request queue and the output register absorb a stalled
// receiver; s_tready drops once the queue is full.
// Reset clears the text state and loads needle length 1 with a zero needle.
module first_substring_match_unit #(
    parameter int unsigned MAX_NEEDLE = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  fsm_pkg::cfg_addr_t            cfg_addr,
    input  fsm_pkg::cfg_data_t            cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fsm_pkg::TEXT_W-1:0]    s_tdata,   // [7:0] text_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fsm_pkg::POS_W-1:0]     m_tdata,   // [31:0] match_position
    output logic                          m_tuser    // [0] found
);
    import fsm_pkg::*;

    logic    push_valid;
    result_t push_data;
    logic    push_ready;
    logic    pop_valid;
    result_t pop_data;
    logic    pop_ready;

    fsm_front #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    fsm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    fsm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the first substring match unit with random texts and stalls.
module testbench;
    import fsm_pkg::*;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned PHASE_BYTES  = 102;
    localparam int unsigned PHASES       = 12;

    typedef enum int unsigned {
        NEEDLE_PAIR,
        NEEDLE_RANDOM,
        NEEDLE_ONES
    } needle_kind_t;

    class match_scoreboard;
        logic [7:0]       needle [32];
        int unsigned      needle_len;
        logic [7:0]       window [32];
        int unsigned      fill;
        logic [POS_W-1:0] seen;
        bit               reported;
        result_t          expected_q[$];
        int unsigned      failures;
        int unsigned      hits;
        int unsigned      misses;

        function new();
            load_needle(6'd1, '0);
            clear_text();
            failures = 0;
            hits = 0;
            misses = 0;
        endfunction

        function void load_needle(logic [NEEDLE_LEN_W-1:0] len_field, logic [255:0] bytes);
            for (int j = 0; j < 32; j++) begin
                needle[j] = bytes[8*j +: 8];
            end
            if (len_field == 0) begin
                needle_len = 1;
            end else if (len_field > 32) begin
                needle_len = 32;
            end else begin
                needle_len = len_field;
            end
        endfunction

        function void clear_text();
            for (int i = 0; i < 32; i++) begin
                window[i] = 8'd0;
            end
            fill = 0;
            seen = '0;
            reported = 1'b0;
        endfunction

        function void note_request(logic [7:0] text_byte, bit last);
            bit               hit;
            bit               saturated;
            logic [POS_W-1:0] start;
            result_t          r;
            if (reported) begin
                if (last) clear_text();
                return;
            end
            saturated = (seen == '1);
            start = seen;
            for (int i = 31; i > 0; i--) begin
                window[i] = window[i-1];
            end
            window[0] = text_byte;
            if (fill < 32) fill++;
            if (!saturated) seen++;
            hit = !saturated && (fill >= needle_len);
            for (int j = 0; j < needle_len; j++) begin
                if (needle[j] != window[needle_len - 1 - j]) hit = 1'b0;
            end
            if (hit) begin
                r.found = 1'b1;
                r.position = start - (needle_len - 1);
                expected_q.push_back(r);
                if (last) begin
                    clear_text();
                end else begin
                    reported = 1'b1;
                end
            end else if (last) begin
                r.found = 1'b0;
                r.position = '0;
                expected_q.push_back(r);
                clear_text();
            end
        endfunction

        function void check_result(logic found, logic [POS_W-1:0] position);
            result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, actual found=%0b position=%0d",
                         $time, found, position);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (found !== e.found) begin
                $display("%0t: found expected %0b actual %0b", $time, e.found, found);
                failures++;
            end
            if (position !== e.position) begin
                $display("%0t: position expected %0d actual %0d", $time, e.position, position);
                failures++;
            end
            if (e.found) begin
                hits++;
            end else begin
                misses++;
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    cfg_addr_t               cfg_addr  = REG_NEEDLE_LENGTH;
    cfg_data_t               cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [TEXT_W-1:0]       s_tdata   = '0;
    logic                    s_tlast   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [POS_W-1:0]        m_tdata;
    logic                    m_tuser;

    match_scoreboard         sb;
    int unsigned             send_idle_pct  = 0;
    int unsigned             recv_stall_pct = 0;
    int unsigned             stall_cycles   = 0;
    int unsigned             bytes_sent     = 0;
    int unsigned             texts_sent     = 0;
    int unsigned             needles_loaded = 0;
    logic [7:0]              needle_b [32];
    int unsigned             eff_len;
    bit                      small_alphabet;
    logic [7:0]              alpha_base;
    bit                      pause_pending  = 1'b0;
    logic [7:0]              text_q[$];

    first_substring_match_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic load_needle(input logic [NEEDLE_LEN_W-1:0] len_field,
                               input logic [255:0] bytes);
        fsm_reg_t word_reg;
        cfg_we <= 1'b1;
        cfg_addr <= REG_NEEDLE_LENGTH;
        cfg_wdata <= cfg_data_t'(len_field);
        @(posedge aclk);
        for (int w = 0; w < 4; w++) begin
            word_reg = fsm_reg_t'(REG_NEEDLE_WORD_0 + w);
            cfg_addr <= word_reg;
            cfg_wdata <= bytes[64*w +: 64];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        sb.load_needle(len_field, bytes);
        for (int j = 0; j < 32; j++) begin
            needle_b[j] = bytes[8*j +: 8];
        end
        eff_len = sb.needle_len;
        needles_loaded++;
    endtask

    task automatic send_request(input logic [7:0] text_byte, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= text_byte;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(text_byte, last);
        bytes_sent++;
        if (last) texts_sent++;
    endtask

    // hold the sender until every predicted result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            if (pause_pending && text_q.size() > 1 && i == text_q.size() / 2) begin
                drain();
                pause_pending = 1'b0;
            end
            send_request(text_q[i], i == text_q.size() - 1);
        end
    endtask

    function automatic logic [7:0] filler();
        if (small_alphabet) return alpha_base + 8'($urandom_range(1));
        if ($urandom_range(1)) return needle_b[$urandom_range(eff_len - 1)];
        return 8'($urandom_range(255));
    endfunction

    function automatic void build_text();
        int unsigned kind;
        int unsigned n;
        int unsigned bad;
        text_q.delete();
        kind = $urandom_range(99);
        if (kind < 60) begin
            repeat ($urandom_range(10)) text_q.push_back(filler());
            bad = eff_len;
            if ($urandom_range(3) == 0) bad = $urandom_range(eff_len - 1);
            for (int j = 0; j < eff_len; j++) begin
                if (j == bad) begin
                    text_q.push_back(needle_b[j] ^ 8'(1 << $urandom_range(7)));
                end else begin
                    text_q.push_back(needle_b[j]);
                end
            end
            repeat ($urandom_range(6)) text_q.push_back(filler());
        end else if (kind < 80 && eff_len > 1) begin
            n = $urandom_range(eff_len - 1, 1);
            for (int j = 0; j < n; j++) begin
                text_q.push_back(needle_b[j]);
            end
        end else begin
            n = $urandom_range(20, 1);
            repeat (n) text_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    initial begin
        int unsigned              phase_start;
        logic [NEEDLE_LEN_W-1:0]  len_field;
        logic [255:0]             bytes;
        needle_kind_t             kind;
        sb = new();
        for (int j = 0; j < 32; j++) begin
            needle_b[j] = 8'd0;
        end
        eff_len = 1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset needle: one zero byte, matched on the final byte
        send_request(8'hFF, 1'b0);
        send_request(8'h00, 1'b1);
        drain();

        // length zero acts as one; bytes after the match are dropped
        load_needle(6'd0, 256'hFF);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h12, 1'b0);
        send_request(8'h34, 1'b1);
        send_request(8'h55, 1'b1);
        drain();

        // text shorter than the needle, then an overlapping prefix
        load_needle(6'd3, 256'h626161);
        send_request(8'h61, 1'b0);
        send_request(8'h62, 1'b1);
        send_request(8'h61, 1'b0);
        send_request(8'h61, 1'b0);
        send_request(8'h61, 1'b0);
        send_request(8'h62, 1'b1);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       len_field = 6'd1;
                1:       len_field = 6'd32;
                2:       len_field = 6'd0;
                3:       len_field = 6'd63;
                4:       len_field = 6'd40;
                5:       len_field = 6'd2;
                6:       len_field = 6'd3;
                7:       len_field = 6'd5;
                8:       len_field = 6'd8;
                9:       len_field = 6'd16;
                10:      len_field = 6'd31;
                default: len_field = 6'($urandom_range(32, 1));
            endcase
            if (p == 1) begin
                kind = NEEDLE_ONES;
            end else if (p % 2 == 0) begin
                kind = NEEDLE_PAIR;
            end else begin
                kind = NEEDLE_RANDOM;
            end
            small_alphabet = (kind == NEEDLE_PAIR);
            alpha_base = 8'($urandom_range(255));
            for (int j = 0; j < 32; j++) begin
                case (kind)
                    NEEDLE_PAIR:   bytes[8*j +: 8] = alpha_base + 8'($urandom_range(1));
                    NEEDLE_RANDOM: bytes[8*j +: 8] = 8'($urandom_range(255));
                    default:       bytes[8*j +: 8] = 8'hFF;
                endcase
            end
            load_needle(len_field, bytes);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            pause_pending = (p == 2);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                build_text();
                send_text();
            end
            drain();
        end

        $display("sent %0d texts, %0d bytes, under %0d needle settings with varied stalls",
                 texts_sent, bytes_sent, needles_loaded + 1);
        $display("checked %0d found and %0d not-found results, %0d mismatches",
                 sb.hits, sb.misses, sb.failures);
        if (sb.failures == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/fsm_pkg.sv
sv/fsm_front.sv
sv/fsm_queue.sv
sv/fsm_back.sv
sv/first_substring_match_unit.sv
bench/testbench.sv
